>>> sv/mcfis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfis_pkg: shared types and constants
// Write kinds, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mcfis_pkg;

    // result write kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_SPEED   = 2'd1;
    localparam logic [1:0] KIND_NEUTRAL = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_DRIVE_ENABLE   = 3'd0;
    localparam logic [2:0] REG_CMD_TIMEOUT    = 3'd1;
    localparam logic [2:0] REG_IDLE_ENABLE    = 3'd2;
    localparam logic [2:0] REG_IDLE_SPEED_PCT = 3'd3;
    localparam logic [2:0] REG_IDLE_PAUSE_MIN = 3'd4;
    localparam logic [2:0] REG_IDLE_PAUSE_MAX = 3'd5;
    localparam logic [2:0] REG_IDLE_MOVE_MS   = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 11;
    localparam int REM_W      = 18;   // pause range below 2^18 ms
    localparam int PAUSE_W    = 19;   // min part plus remainder
    localparam int DIV_CNT_W  = 5;    // 32 remainder steps

    localparam logic signed [SPEED_W-1:0] SPEED_FULL     = 11'sd1000;
    localparam logic        [6:0]         PCT_FULL       = 7'd100;
    localparam logic        [9:0]         MS_PER_S       = 10'd1000;
    localparam logic        [3:0]         PCT_TO_SPEED   = 4'd10;
    localparam logic        [15:0]        TIMEOUT_RESET  = 16'd500;
    localparam logic [DIV_CNT_W-1:0]      DIV_LAST_STEP  = 5'd31;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_PAUSE = 4'b0100,
        ST_PUSH  = 4'b1000
    } mcfis_state_t;

    typedef struct packed {
        logic load;         // latch item, start remainder unit
        logic div_step;     // one restoring step
        logic pause_load;   // register the pause length
        logic commit;       // update state, load the result register
    } mcfis_cmd_t;

    typedef struct packed {
        logic div_last;     // current step is the final one
        logic out_free;     // result register empty or being taken
    } mcfis_sts_t;

endpackage

>>> sv/mcfis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfis_ctrl: item sequencer
// Steps an item through remainder, pause and commit phases.
// ----------------------------------------------------------------------------
module mcfis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcfis_pkg::mcfis_sts_t sts,
    output mcfis_pkg::mcfis_cmd_t cmd
);

    mcfis_pkg::mcfis_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcfis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcfis_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mcfis_pkg::ST_DIV;
                end
            end
            mcfis_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = mcfis_pkg::ST_PAUSE;
                end
            end
            mcfis_pkg::ST_PAUSE:
            begin
                state_next = mcfis_pkg::ST_PUSH;
            end
            mcfis_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = mcfis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcfis_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready       = (state_reg == mcfis_pkg::ST_IDLE);
    assign cmd.load       = in_ready && in_valid;
    assign cmd.div_step   = (state_reg == mcfis_pkg::ST_DIV);
    assign cmd.pause_load = (state_reg == mcfis_pkg::ST_PAUSE);
    assign cmd.commit     = (state_reg == mcfis_pkg::ST_PUSH) && sts.out_free;

endmodule

>>> sv/mcfis_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfis_dp: datapath
// Config registers, item registers, bit-serial remainder unit, tick update
// logic, sequencer state and the result register.
// ----------------------------------------------------------------------------
module mcfis_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [31:0]         now_ms,
    input  logic                sleep_mode,
    input  logic                emergency_stop,
    input  logic                sequence_active,
    input  logic                command_valid,
    input  logic signed [10:0]  command_speed,
    input  logic [31:0]         random_word,
    input  mcfis_pkg::mcfis_cmd_t cmd,
    output mcfis_pkg::mcfis_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          write_kind,
    output logic signed [10:0]  drive_speed
);

    // configuration
    logic        drive_enable_reg;
    logic [15:0] timeout_reg;
    logic        idle_enable_reg;
    logic [6:0]  idle_pct_reg;
    logic [7:0]  pause_min_reg;
    logic [7:0]  pause_max_reg;
    logic [15:0] move_ms_reg;

    // item
    logic [31:0]        now_reg;
    logic               sleep_reg;
    logic               estop_reg;
    logic               seq_reg;
    logic               cmd_valid_reg;
    logic signed [10:0] cmd_speed_reg;
    logic               rnd_bit_reg;

    // remainder unit
    logic [31:0]                          dvd_reg;
    logic [mcfis_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [mcfis_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [mcfis_pkg::PAUSE_W-1:0]        pause_reg;

    // sequencer state
    logic signed [10:0] speed_reg,   speed_next;
    logic [31:0]        lct_reg,     lct_next;
    logic               held_reg,    held_next;
    logic               sleeph_reg,  sleeph_next;
    logic               moving_reg,  moving_next;
    logic [31:0]        dl_reg,      dl_next;
    logic               was_act_reg, was_act_next;
    logic [1:0]         kind_next;

    // result register
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic signed [10:0] out_speed_reg;

    logic [mcfis_pkg::REM_W-1:0] range;
    logic [mcfis_pkg::REM_W:0]   trial;
    logic [mcfis_pkg::REM_W:0]   trial_sub;
    logic [mcfis_pkg::REM_W-1:0] min_ms;
    logic [mcfis_pkg::REM_W-1:0] rem_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_enable_reg <= 1'b1;
            timeout_reg      <= mcfis_pkg::TIMEOUT_RESET;
            idle_enable_reg  <= 1'b0;
            idle_pct_reg     <= '0;
            pause_min_reg    <= '0;
            pause_max_reg    <= '0;
            move_ms_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcfis_pkg::REG_DRIVE_ENABLE:   drive_enable_reg <= cfg_data[0];
                mcfis_pkg::REG_CMD_TIMEOUT:    timeout_reg      <= cfg_data;
                mcfis_pkg::REG_IDLE_ENABLE:    idle_enable_reg  <= cfg_data[0];
                mcfis_pkg::REG_IDLE_SPEED_PCT: idle_pct_reg     <= cfg_data[6:0];
                mcfis_pkg::REG_IDLE_PAUSE_MIN: pause_min_reg    <= cfg_data[7:0];
                mcfis_pkg::REG_IDLE_PAUSE_MAX: pause_max_reg    <= cfg_data[7:0];
                mcfis_pkg::REG_IDLE_MOVE_MS:   move_ms_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // pause range in ms, zero when max does not exceed min
    assign range  = (pause_max_reg > pause_min_reg)
                  ? mcfis_pkg::REM_W'(pause_max_reg - pause_min_reg)
                    * mcfis_pkg::REM_W'(mcfis_pkg::MS_PER_S)
                  : '0;
    assign min_ms = mcfis_pkg::REM_W'(pause_min_reg) * mcfis_pkg::REM_W'(mcfis_pkg::MS_PER_S);

    // restoring remainder step, dividend MSB first
    assign trial     = {rem_reg, dvd_reg[31]};
    assign trial_sub = trial - {1'b0, range};
    assign rem_next  = (trial >= {1'b0, range}) ? trial_sub[mcfis_pkg::REM_W-1:0]
                                                 : trial[mcfis_pkg::REM_W-1:0];
    assign rem_used  = (range != '0) ? rem_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg       <= now_ms;
            sleep_reg     <= sleep_mode;
            estop_reg     <= emergency_stop;
            seq_reg       <= sequence_active;
            cmd_valid_reg <= command_valid;
            cmd_speed_reg <= command_speed;
            rnd_bit_reg   <= random_word[0];
            dvd_reg       <= random_word;
            rem_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.pause_load)
        begin
            pause_reg <= mcfis_pkg::PAUSE_W'(min_ms) + mcfis_pkg::PAUSE_W'(rem_used);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign sts.div_last = (cnt_reg == mcfis_pkg::DIV_LAST_STEP);
    assign sts.out_free = !out_valid_reg || out_ready;

    // tick update
    always_comb
    begin
        logic signed [10:0] cmd_sat;
        logic [6:0]         pct_lim;
        logic [10:0]        mag_u;
        logic signed [10:0] mag;
        logic [31:0]        elapsed;
        logic [31:0]        since_dl;
        logic [31:0]        dl_pause;
        logic [31:0]        dl_move;
        logic               manual;
        logic               reached;

        cmd_sat = cmd_speed_reg;
        if (cmd_speed_reg > mcfis_pkg::SPEED_FULL)
        begin
            cmd_sat = mcfis_pkg::SPEED_FULL;
        end
        else if (cmd_speed_reg < -mcfis_pkg::SPEED_FULL)
        begin
            cmd_sat = -mcfis_pkg::SPEED_FULL;
        end
        pct_lim  = (idle_pct_reg > mcfis_pkg::PCT_FULL) ? mcfis_pkg::PCT_FULL : idle_pct_reg;
        mag_u    = 11'(pct_lim) * 11'(mcfis_pkg::PCT_TO_SPEED);
        mag      = signed'(mag_u);
        dl_pause = now_reg + 32'(pause_reg);
        dl_move  = now_reg + 32'(move_ms_reg);
        manual   = 1'b0;
        elapsed  = '0;
        since_dl = '0;
        reached  = 1'b0;

        speed_next   = speed_reg;
        lct_next     = lct_reg;
        held_next    = held_reg;
        sleeph_next  = sleeph_reg;
        moving_next  = moving_reg;
        dl_next      = dl_reg;
        was_act_next = was_act_reg;
        kind_next    = mcfis_pkg::KIND_NONE;

        if (!drive_enable_reg)
        begin
            if (speed_reg != '0)
            begin
                speed_next = '0;
                kind_next  = mcfis_pkg::KIND_NEUTRAL;
            end
            held_next   = 1'b0;
            sleeph_next = 1'b0;
        end
        else if (sleep_reg)
        begin
            if (!sleeph_reg || speed_reg != '0)
            begin
                speed_next = '0;
                kind_next  = mcfis_pkg::KIND_NEUTRAL;
            end
            sleeph_next = 1'b1;
            held_next   = 1'b0;
        end
        else
        begin
            sleeph_next = 1'b0;
            if (estop_reg && speed_next != '0)
            begin
                speed_next = '0;
                kind_next  = mcfis_pkg::KIND_NEUTRAL;
            end
            if (!estop_reg && cmd_valid_reg)
            begin
                speed_next = cmd_sat;
                lct_next   = now_reg;
                held_next  = 1'b1;
                manual     = 1'b1;
                kind_next  = mcfis_pkg::KIND_SPEED;
            end
            elapsed = now_reg - lct_next;
            if (held_next && elapsed > 32'(timeout_reg))
            begin
                if (speed_next != '0)
                begin
                    speed_next = '0;
                    kind_next  = mcfis_pkg::KIND_NEUTRAL;
                end
                held_next = 1'b0;
            end

            since_dl = now_reg - dl_reg;
            reached  = !since_dl[31];
            if (idle_enable_reg && !estop_reg && !seq_reg)
            begin
                if (!was_act_reg)
                begin
                    moving_next  = 1'b0;
                    dl_next      = dl_pause;
                    was_act_next = 1'b1;
                end
                else if (manual)
                begin
                    moving_next = 1'b0;
                    dl_next     = dl_pause;
                end
                else if (!moving_reg && reached)
                begin
                    speed_next  = rnd_bit_reg ? mag : -mag;
                    lct_next    = now_reg;
                    held_next   = 1'b1;
                    moving_next = 1'b1;
                    dl_next     = dl_move;
                    kind_next   = mcfis_pkg::KIND_SPEED;
                end
                else if (moving_reg)
                begin
                    if (reached)
                    begin
                        speed_next  = '0;
                        held_next   = 1'b0;
                        moving_next = 1'b0;
                        dl_next     = dl_pause;
                        kind_next   = mcfis_pkg::KIND_NEUTRAL;
                    end
                    else
                    begin
                        lct_next = now_reg;
                    end
                end
            end
            else
            begin
                was_act_next = 1'b0;
                if (moving_reg)
                begin
                    speed_next  = '0;
                    held_next   = 1'b0;
                    dl_next     = now_reg;
                    moving_next = 1'b0;
                    kind_next   = mcfis_pkg::KIND_NEUTRAL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg   <= '0;
            lct_reg     <= '0;
            held_reg    <= 1'b0;
            sleeph_reg  <= 1'b0;
            moving_reg  <= 1'b0;
            dl_reg      <= '0;
            was_act_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            speed_reg   <= speed_next;
            lct_reg     <= lct_next;
            held_reg    <= held_next;
            sleeph_reg  <= sleeph_next;
            moving_reg  <= moving_next;
            dl_reg      <= dl_next;
            was_act_reg <= was_act_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            kind_reg      <= kind_next;
            out_speed_reg <= speed_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_kind  = kind_reg;
    assign drive_speed = out_speed_reg;

endmodule

>>> sv/motor_command_failsafe_idle_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_failsafe_idle_sequencer: motor speed failsafe and idle moves
// Per tick: applies disable, sleep, e-stop and command timeout rules, runs
// the random pause/move idle machine and reports the last speed write.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | now_ms, flags, command, random_word
//  out      | out_valid/ out_ready | write_kind, drive_speed
//  cfg      | cfg_we               | cfg_index, cfg_data (no wait)
//
//  An item passes from acceptance to commit through a load, 32 steps of
//  the bit-serial remainder unit (random word mod pause range), a pause
//  add and a commit.
//  in_ready is high only in the idle state; the next item may be accepted
//  while the previous result still waits in the output register.
//  Commit waits while the output register is full and not being taken.
//  Reset clears state and control and loads the register defaults.
//
module motor_command_failsafe_idle_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        now_ms,
    input  logic               sleep_mode,
    input  logic               emergency_stop,
    input  logic               sequence_active,
    input  logic               command_valid,
    input  logic signed [10:0] command_speed,
    input  logic [31:0]        random_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         write_kind,
    output logic signed [10:0] drive_speed
);

    mcfis_pkg::mcfis_cmd_t cmd;
    mcfis_pkg::mcfis_sts_t sts;

    // sequencer: idle -> remainder steps -> pause add -> commit
    mcfis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: registers, remainder unit, tick rules, result register
    mcfis_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .now_ms          (now_ms),
        .sleep_mode      (sleep_mode),
        .emergency_stop  (emergency_stop),
        .sequence_active (sequence_active),
        .command_valid   (command_valid),
        .command_speed   (command_speed),
        .random_word     (random_word),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .write_kind      (write_kind),
        .drive_speed     (drive_speed)
    );

endmodule

>>> sv/mcfis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfis_checker: port-level checks
// Watches the top level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module mcfis_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         write_kind,
    input logic signed [10:0] drive_speed
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // neutral write leaves the speed at zero
    a_neutral_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_kind == mcfis_pkg::KIND_NEUTRAL) |-> drive_speed == '0)
        else $error("neutral write with non-zero speed");

    // speed stays in range and the kind is a known code
    a_result_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_speed <= mcfis_pkg::SPEED_FULL &&
                       drive_speed >= -mcfis_pkg::SPEED_FULL &&
                       (write_kind == mcfis_pkg::KIND_NONE ||
                        write_kind == mcfis_pkg::KIND_SPEED ||
                        write_kind == mcfis_pkg::KIND_NEUTRAL)))
        else $error("illegal result");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(write_kind) && $stable(drive_speed)))
        else $error("result changed while stalled");

endmodule

bind motor_command_failsafe_idle_sequencer mcfis_checker u_mcfis_checker (.*);
